### hdl/apsp_pkg.sv
// apsp_pkg: shared types and constants for the all-pairs shortest path block
// no dependencies; imported by every module in hdl/
package apsp_pkg;

   localparam int DIST_W = 10;
   localparam int FIELD_W = 4;
   localparam int KIND_W = 2;
   localparam int CSR_W = 5;

   localparam logic [DIST_W-1:0] NO_EDGE = 10'd1000;
   localparam logic [CSR_W-1:0] NODE_COUNT_RESET = 5'd16;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RUN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [FIELD_W-1:0] row;
      logic [FIELD_W-1:0] col;
      logic [DIST_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic unreachable;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic fetch;    // read dist(s,i) for the coming row sweep
      logic relax;    // read dist(i,d) and dist(s,d), relax in the cycle after
      logic finish;   // run done, post its word
   } ctl_cmd_type;

   // controller to top
   typedef struct packed {
      logic idle;
   } ctl_status_type;

endpackage

### hdl/apsp_out_queue.sv
// apsp_out_queue: two-word result queue in front of the rsp channel
// depends on apsp_pkg
module apsp_out_queue
   import apsp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  rsp_type push_data,
   output logic [1:0] count,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data
);

   logic [1:0] count_ff, count_in, count_mid;
   rsp_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic pop;

   always_comb begin
      pop = (count_ff != 2'd0) && rsp_ready;
      count_mid = count_ff - 2'(pop);
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      if (push) begin
         if (count_mid == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end
      count_in = count_mid + 2'(push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign count = count_ff;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data = slot0_ff;

endmodule

### hdl/apsp_ctl.sv
// apsp_ctl: run sequencer, walks intermediate i, source s, destination d
// depends on apsp_pkg
module apsp_ctl
   import apsp_pkg::*;
#(
   parameter int MAX_NODES = 16,
   parameter int NODE_W = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [CSR_W-1:0] node_count,
   output ctl_cmd_type cmd,
   output ctl_status_type status,
   output logic [NODE_W-1:0] idx_i,
   output logic [NODE_W-1:0] idx_s,
   output logic [NODE_W-1:0] idx_d
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_SWEEP = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [NODE_W-1:0] i_ff, i_in, s_ff, s_in, d_ff, d_in, last_ff, last_in;
   logic [NODE_W-1:0] n_last;

   // clamp node count into 1..MAX_NODES
   always_comb begin
      if (node_count == '0) begin
         n_last = '0;
      end else if (int'(node_count) > MAX_NODES) begin
         n_last = NODE_W'(MAX_NODES - 1);
      end else begin
         n_last = NODE_W'(node_count - 5'd1);
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      s_in = s_ff;
      d_in = d_ff;
      last_in = last_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               i_in = '0;
               s_in = '0;
               d_in = '0;
               last_in = n_last;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            d_in = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.relax = 1'b1;
            if (d_ff == last_ff) begin
               d_in = '0;
               if (s_ff == last_ff) begin
                  s_in = '0;
                  if (i_ff == last_ff) begin
                     state_in = ST_DRAIN;
                  end else begin
                     i_in = i_ff + NODE_W'(1);
                     state_in = ST_FETCH;
                  end
               end else begin
                  s_in = s_ff + NODE_W'(1);
                  state_in = ST_FETCH;
               end
            end else begin
               d_in = d_ff + NODE_W'(1);
            end
         end
         ST_DRAIN: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      s_ff <= s_in;
      d_ff <= d_in;
      last_ff <= last_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign idx_i = i_ff;
   assign idx_s = s_ff;
   assign idx_d = d_ff;

endmodule

### hdl/apsp_dp.sv
// apsp_dp: distance matrix memory, relax pipeline and load/read word path
// depends on apsp_pkg
module apsp_dp
   import apsp_pkg::*;
#(
   parameter int MAX_NODES = 16,
   parameter int NODE_W = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic req_fire,
   input  req_type req_data,
   input  ctl_cmd_type cmd,
   input  logic [NODE_W-1:0] idx_i,
   input  logic [NODE_W-1:0] idx_s,
   input  logic [NODE_W-1:0] idx_d,
   output logic push,
   output rsp_type push_data
);

   localparam int ADDR_W = 2 * NODE_W;
   localparam int DEPTH = 2 ** ADDR_W;

   logic [DIST_W-1:0] dist_ff [DEPTH];
   logic [DIST_W-1:0] rd_a_ff, rd_b_ff;
   logic [ADDR_W-1:0] rd_addr_a_in, rd_addr_b_in;

   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DIST_W-1:0] wr_data;

   // relax pipeline
   logic cap_ff, cap_zero_ff;
   logic [DIST_W-1:0] sik_ff, sik_in;
   logic rel_ff, a_zero_ff, b_zero_ff;
   logic [ADDR_W-1:0] rel_addr_ff;
   logic [DIST_W-1:0] a_val, b_val;
   logic [DIST_W:0] via;
   logic relax_wr;

   // item stage
   logic p1_valid_ff, p1_valid_in;
   logic [KIND_W-1:0] p1_kind_ff, p1_kind_in;
   logic p1_diag_ff, p1_oob_ff;

   logic [NODE_W-1:0] row_idx, col_idx;
   logic in_range, is_diag, load_wr;
   logic [DIST_W-1:0] load_val;

   always_comb begin
      row_idx = NODE_W'(req_data.row);
      col_idx = NODE_W'(req_data.col);
      in_range = (int'(req_data.row) < MAX_NODES) && (int'(req_data.col) < MAX_NODES);
      is_diag = (req_data.row == req_data.col);
      load_val = (req_data.weight > NO_EDGE) ? NO_EDGE : req_data.weight;
      if (is_diag) begin
         load_val = '0;
      end
      load_wr = req_fire && (req_data.kind == KIND_LOAD) && in_range;
   end

   // read addresses: relax uses (i,d) and (s,d), fetch uses (s,i), items use row/col
   always_comb begin
      if (cmd.relax) begin
         rd_addr_a_in = {idx_i, idx_d};
      end else begin
         rd_addr_a_in = {row_idx, col_idx};
      end
      if (cmd.fetch) begin
         rd_addr_b_in = {idx_s, idx_i};
      end else begin
         rd_addr_b_in = {idx_s, idx_d};
      end
   end

   // diagonal always reads as zero
   always_comb begin
      a_val = a_zero_ff ? '0 : rd_a_ff;
      b_val = b_zero_ff ? '0 : rd_b_ff;
      via = {1'b0, sik_ff} + {1'b0, a_val};
      relax_wr = rel_ff && (via < {1'b0, b_val});
      sik_in = cap_ff ? (cap_zero_ff ? '0 : rd_b_ff) : sik_ff;
   end

   always_comb begin
      if (relax_wr) begin
         wr_en = 1'b1;
         wr_addr = rel_addr_ff;
         wr_data = via[DIST_W-1:0];
      end else begin
         wr_en = load_wr;
         wr_addr = {row_idx, col_idx};
         wr_data = load_val;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= dist_ff[rd_addr_a_in];
      rd_b_ff <= dist_ff[rd_addr_b_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 1'b0;
         rel_ff <= 1'b0;
      end else begin
         cap_ff <= cmd.fetch;
         rel_ff <= cmd.relax;
      end
   end

   always_ff @(posedge clock) begin
      cap_zero_ff <= (idx_s == idx_i);
      sik_ff <= sik_in;
      a_zero_ff <= (idx_i == idx_d);
      b_zero_ff <= (idx_s == idx_d);
      rel_addr_ff <= {idx_s, idx_d};
   end

   // one word per item: load/read in the cycle after accept, run at finish
   always_comb begin
      p1_valid_in = 1'b0;
      p1_kind_in = p1_kind_ff;
      if (cmd.finish) begin
         p1_valid_in = 1'b1;
         p1_kind_in = KIND_RUN;
      end else if (req_fire && (req_data.kind != KIND_RUN)) begin
         p1_valid_in = 1'b1;
         p1_kind_in = req_data.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_kind_ff <= p1_kind_in;
      p1_diag_ff <= is_diag;
      p1_oob_ff <= !in_range;
   end

   always_comb begin
      push = p1_valid_ff;
      push_data = '0;
      if (p1_kind_ff == KIND_READ) begin
         if (p1_oob_ff) begin
            push_data.distance = NO_EDGE;
         end else if (p1_diag_ff) begin
            push_data.distance = '0;
         end else begin
            push_data.distance = rd_a_ff;
         end
         push_data.unreachable = (push_data.distance >= NO_EDGE);
      end
   end

endmodule

### hdl/all_pairs_shortest_paths.sv
// all_pairs_shortest_paths: floyd-warshall shortest paths over an on-chip weight matrix
// usage notes below; depends on apsp_pkg, apsp_ctl, apsp_dp, apsp_out_queue
//
// req channel (valid/ready) carries one word per item: load a weight, run the
// relaxation, or read a distance. rsp channel returns exactly one word per item,
// in order: the distance for a read, zeros for load and run.
// csr_wen/csr_wdata write node_count (reset 16); write it only while idle.
//
// load and read: result word goes through the item stage, then the output queue;
// one item per cycle sustained while rsp_ready is high, limited by the single
// write port and registered read ports. run: the sequencer walks i, then s,
// fetching dist(s,i) in one state, then sweeping d over the two read ports,
// then passing a drain state before the result word, with d, s and i ranging
// over node_count clamped to 1..MAX_NODES. req_ready is low for the whole run.
//
// a two-word output queue decouples the sides; while rsp_ready is low the
// block keeps taking items until the queue plus the item in flight fill it.
// reset clears control state only; matrix entries are undefined until loaded,
// and the diagonal always reads as zero.
module all_pairs_shortest_paths
   import apsp_pkg::*;
#(
   parameter int MAX_NODES = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic csr_wen,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int NODE_W = $clog2(MAX_NODES);

   logic [CSR_W-1:0] node_count_ff, node_count_in;

   ctl_cmd_type ctl_cmd;
   ctl_status_type ctl_status;
   logic [NODE_W-1:0] idx_i, idx_s, idx_d;

   logic req_fire, run_start;
   logic p1_push, rsp_pop;
   rsp_type p1_data;
   logic [1:0] q_count;
   logic [2:0] in_flight;

   // node count register
   assign node_count_in = csr_wen ? csr_wdata : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   // words already queued or in the item stage, less the one leaving now
   assign rsp_pop = rsp_valid && rsp_ready;
   assign in_flight = 3'(q_count) + 3'(p1_push) - 3'(rsp_pop);
   assign req_ready = ctl_status.idle && (in_flight < 3'd2);
   assign req_fire = req_valid && req_ready;
   assign run_start = req_fire && (req_data.kind == KIND_RUN);

   apsp_ctl #(
      .MAX_NODES(MAX_NODES),
      .NODE_W(NODE_W)
   ) u_ctl (
      .clock(clock),
      .reset(reset),
      .start(run_start),
      .node_count(node_count_ff),
      .cmd(ctl_cmd),
      .status(ctl_status),
      .idx_i(idx_i),
      .idx_s(idx_s),
      .idx_d(idx_d)
   );

   apsp_dp #(
      .MAX_NODES(MAX_NODES),
      .NODE_W(NODE_W)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .req_fire(req_fire),
      .req_data(req_data),
      .cmd(ctl_cmd),
      .idx_i(idx_i),
      .idx_s(idx_s),
      .idx_d(idx_d),
      .push(p1_push),
      .push_data(p1_data)
   );

   apsp_out_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(p1_push),
      .push_data(p1_data),
      .count(q_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   // queue never takes a word it has no room for
   assert property (@(posedge clock) disable iff (reset)
      !(p1_push && (q_count == 2'd2) && !rsp_pop))
      else $error("result queue overflow");

   // sequencer issues at most one command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl_cmd.fetch, ctl_cmd.relax, ctl_cmd.finish}))
      else $error("conflicting sequencer commands");

   // a run holds the block busy from the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      run_start |=> !ctl_status.idle && !p1_push)
      else $error("run did not start");

   // unreachable flag only with the no-edge distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.unreachable |-> rsp_data.distance == NO_EDGE)
      else $error("unreachable flag without no-edge distance");

endmodule
